// ===== hdl/trnf_pkg.sv =====
package trnf_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int REG_W     = 17;
    localparam int SUM_W     = 63;
    localparam int CNT_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FRACTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TAIL      = 2'd2;

    localparam logic [REG_W-1:0] FRAC_ONE      = 17'd65536;
    localparam logic [REG_W-1:0] FRAC_DEFAULT  = 17'd6554;
    localparam logic [16:0]      DB_FLOOR      = 17'd76800;
    localparam logic [26:0]      DB_PER_LOG2   = 27'd101008905;
    localparam logic [CNT_W-1:0] DIV_STEPS     = 7'd78;
    localparam logic [CNT_W-1:0] SQRT_STEPS    = 7'd31;
    localparam logic [CNT_W-1:0] LOG_STEPS     = 7'd15;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DRAIN = 10'b0000000010,
        ST_DIV   = 10'b0000000100,
        ST_SQRT  = 10'b0000001000,
        ST_LOADN = 10'b0000010000,
        ST_NORM  = 10'b0000100000,
        ST_LOG   = 10'b0001000000,
        ST_MUL   = 10'b0010000000,
        ST_FIN   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             clr;
        logic             div_step;
        logic             sqrt_step;
        logic             norm_load;
        logic             norm_step;
        logic             log_step;
        logic             mul;
        logic             fin;
        logic             emit;
        logic             sel;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic norm_zero;
        logic norm_msb;
    } status_t;

endpackage

// ===== hdl/trnf_ctrl.sv =====
module trnf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  trnf_pkg::status_t status,
    output trnf_pkg::cmd_t    cmd
);
    import trnf_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.cnt    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start && status.last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.clr    = 1'b1;
                cnt_next   = DIV_STEPS;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = SQRT_STEPS;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    sel_next   = 1'b0;
                    state_next = ST_LOADN;
                end
            end
            ST_LOADN:
            begin
                cmd.norm_load = 1'b1;
                state_next    = ST_NORM;
            end
            ST_NORM:
            begin
                if (status.norm_zero)
                    state_next = ST_FIN;
                else if (status.norm_msb)
                begin
                    cnt_next   = LOG_STEPS;
                    state_next = ST_LOG;
                end
                else
                    cmd.norm_step = 1'b1;
            end
            ST_LOG:
            begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_LOADN;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && status.last |=> busy)
        else $error("last sample did not start finishing");
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy)
        else $error("block not idle after result");
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.div_step, cmd.sqrt_step, cmd.norm_step, cmd.log_step, cmd.mul, cmd.fin}))
        else $error("more than one unit stepped");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !busy && start)
        else $error("transaction taken while busy");

endmodule

// ===== hdl/trnf_dp.sv =====
module trnf_dp #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  trnf_pkg::cmd_t                      cmd,
    output trnf_pkg::status_t                   status,
    input  logic                                cfg_valid,
    input  logic [trnf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trnf_pkg::REG_W-1:0]          cfg_data,
    input  logic [23:0]                         sample,
    output logic                                done,
    output logic [31:0]                         noise_rms,
    output logic signed [17:0]                  noise_floor_db,
    output logic [23:0]                         peak_abs,
    output logic signed [17:0]                  peak_db,
    output logic [16:0]                         dynamic_range_db,
    output logic [15:0]                         tail_start,
    output logic [16:0]                         tail_count,
    output logic                                tail_clamped
);
    import trnf_pkg::*;

    localparam logic [REG_W-1:0] N_MAX     = REG_W'(MAX_SAMPLES);
    localparam logic [21:0]      REF_NOISE = 22'(SAMPLE_BITS + 7) << 16;
    localparam logic [21:0]      REF_PEAK  = 22'(SAMPLE_BITS - 1) << 16;

    // configuration registers
    logic [REG_W-1:0] len_reg, frac_reg, mint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 17'd1;
            frac_reg <= FRAC_DEFAULT;
            mint_reg <= 17'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RECORD_LENGTH: len_reg  <= cfg_data;
                REG_TAIL_FRACTION: frac_reg <= cfg_data;
                REG_MIN_TAIL:      mint_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // window setup
    logic [REG_W-1:0] n_c, frac_c, mt_c, tail_c, start_c;
    logic [33:0]      prod_win;
    logic             cut_c;

    always_comb
    begin
        n_c = len_reg;
        if (len_reg == '0)
            n_c = 17'd1;
        else if (len_reg > N_MAX)
            n_c = N_MAX;
        frac_c = frac_reg;
        if (frac_reg == '0 || frac_reg > FRAC_ONE)
            frac_c = FRAC_DEFAULT;
        mt_c = (mint_reg == '0) ? 17'd1 : mint_reg;
        prod_win = 34'(n_c) * 34'(frac_c) + 34'd32768;
        tail_c   = prod_win[32:16];
        if (tail_c < mt_c)
            tail_c = mt_c;
        cut_c = (tail_c > n_c);
        if (cut_c)
            tail_c = n_c;
        start_c = n_c - tail_c;
    end

    // sample stream
    logic [REG_W-1:0]       idx_reg, wstart_reg, wcount_reg, end_reg;
    logic                   wcut_reg;
    logic [23:0]            peak_reg;
    logic [SAMPLE_BITS-1:0] raw, mag_c;
    logic [23:0]            mag24;
    logic                   first;
    logic [REG_W-1:0]       cur_start, cur_end;
    logic [23:0]            mag_s_reg;
    logic                   tail_s_reg, first_s_reg, vld_s_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [47:0]            sq;

    assign raw       = sample[SAMPLE_BITS-1:0];
    assign mag_c     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign mag24     = 24'(mag_c);
    assign first     = (idx_reg == '0);
    assign cur_start = first ? start_c : wstart_reg;
    assign cur_end   = first ? n_c : end_reg;
    assign status.last = ((18'(idx_reg) + 18'd1) == 18'(cur_end));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            wstart_reg <= '0;
            wcount_reg <= 17'd1;
            end_reg    <= 17'd1;
            wcut_reg   <= 1'b0;
            peak_reg   <= '0;
            vld_s_reg  <= 1'b0;
            sum_reg    <= '0;
        end
        else
        begin
            vld_s_reg <= cmd.accept;
            if (cmd.accept)
            begin
                idx_reg <= status.last ? '0 : idx_reg + 1'b1;
                if (first)
                begin
                    wstart_reg <= start_c;
                    wcount_reg <= tail_c;
                    end_reg    <= n_c;
                    wcut_reg   <= cut_c;
                    peak_reg   <= mag24;
                end
                else if (mag24 > peak_reg)
                    peak_reg <= mag24;
            end
            if (vld_s_reg)
                sum_reg <= (first_s_reg ? '0 : sum_reg) +
                           (tail_s_reg ? SUM_W'(sq) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_s_reg   <= mag24;
            tail_s_reg  <= (idx_reg >= cur_start);
            first_s_reg <= first;
        end
    end

    assign sq = 48'(mag_s_reg) * 48'(mag_s_reg);

    // mean = floor(sum * 2^16 / count), one quotient bit per cycle
    logic [SUM_W+15:0] dividend;
    logic [17:0]       drem_reg, drem_sh;
    logic [63:0]       quot_reg;
    logic              dge;

    assign dividend = {sum_reg, 16'd0};
    assign drem_sh  = {drem_reg[16:0], dividend[cmd.cnt]};
    assign dge      = (drem_sh >= {1'b0, wcount_reg});

    // floor square root, two radicand bits per cycle
    logic [31:0] root_reg;
    logic [33:0] srem_reg;
    logic [35:0] srem_sh, trial;
    logic        sge;

    assign srem_sh = {srem_reg, quot_reg[{cmd.cnt[4:0], 1'b1}], quot_reg[{cmd.cnt[4:0], 1'b0}]};
    assign trial   = 36'({root_reg, 2'b01});
    assign sge     = (srem_sh >= trial);

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            drem_reg <= '0;
            quot_reg <= '0;
            root_reg <= '0;
            srem_reg <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                drem_reg <= dge ? drem_sh - {1'b0, wcount_reg} : drem_sh;
                quot_reg <= {quot_reg[62:0], dge};
            end
            if (cmd.sqrt_step)
            begin
                srem_reg <= sge ? 34'(srem_sh - trial) : srem_sh[33:0];
                root_reg <= {root_reg[30:0], sge};
            end
        end
    end

    // level in dB: normalize, log2 by repeated squaring, scale
    logic [31:0] v_reg;
    logic [4:0]  e_reg;
    logic [15:0] lfrac_reg;
    logic        zero_reg;
    logic [63:0] psq;
    logic [21:0] lq, refk, diff;
    logic [48:0] prod_reg, rnd;
    logic [16:0] att_c;
    logic [16:0] natt_reg, patt_reg;

    assign status.norm_zero = (v_reg == '0);
    assign status.norm_msb  = v_reg[31];
    assign psq  = 64'(v_reg) * 64'(v_reg);
    assign lq   = {1'b0, e_reg, lfrac_reg};
    assign refk = cmd.sel ? REF_PEAK : REF_NOISE;
    assign diff = (lq >= refk) ? '0 : refk - lq;
    assign rnd  = prod_reg + 49'(33'h080000000);

    always_comb
    begin
        att_c = DB_FLOOR;
        if (!zero_reg && rnd[48:32] < DB_FLOOR)
            att_c = rnd[48:32];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.norm_load)
        begin
            v_reg     <= cmd.sel ? 32'(peak_reg) : root_reg;
            e_reg     <= 5'd31;
            lfrac_reg <= '0;
        end
        else if (cmd.norm_step)
        begin
            v_reg <= {v_reg[30:0], 1'b0};
            e_reg <= e_reg - 1'b1;
        end
        else if (cmd.log_step)
        begin
            if (psq[63])
            begin
                v_reg <= psq[63:32];
                lfrac_reg[cmd.cnt[3:0]] <= 1'b1;
            end
            else
                v_reg <= psq[62:31];
        end
        if (cmd.norm_load)
            zero_reg <= 1'b0;
        else if (status.norm_zero && !cmd.norm_step && !cmd.log_step && !cmd.mul && !cmd.fin)
            zero_reg <= 1'b1;
        if (cmd.mul)
            prod_reg <= 49'(diff) * 49'(DB_PER_LOG2);
        if (cmd.fin)
        begin
            if (cmd.sel)
                patt_reg <= att_c;
            else
                natt_reg <= att_c;
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            noise_rms        <= root_reg;
            noise_floor_db   <= -$signed({1'b0, natt_reg});
            peak_abs         <= peak_reg;
            peak_db          <= -$signed({1'b0, patt_reg});
            dynamic_range_db <= (natt_reg > patt_reg) ? natt_reg - patt_reg : '0;
            tail_start       <= wstart_reg[15:0];
            tail_count       <= wcount_reg;
            tail_clamped     <= wcut_reg;
        end
    end

endmodule

// ===== hdl/tail_rms_noise_floor_unit.sv =====
// Accepts one sample per cycle while busy is low; records must be fed back to back or with gaps.
// After the edge that takes the last sample of a record, the block drains the square stage, then
// runs the bit-serial divide, square root and two log passes (noise, then peak) before done rises.
// Busy stays high through all of this, so no sample is taken until it falls; done lasts one cycle,
// no stall. Reset: asynchronous active low; config registers to defaults, index to record start.
module tail_rms_noise_floor_unit #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [23:0]                    sample,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [trnf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [trnf_pkg::REG_W-1:0]     cfg_data,
    output logic                           done,
    output logic [31:0]                    noise_rms,
    output logic signed [17:0]             noise_floor_db,
    output logic [23:0]                    peak_abs,
    output logic signed [17:0]             peak_db,
    output logic [16:0]                    dynamic_range_db,
    output logic [15:0]                    tail_start,
    output logic [16:0]                    tail_count,
    output logic                           tail_clamped
);
    import trnf_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    trnf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    trnf_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample           (sample),
        .done             (done),
        .noise_rms        (noise_rms),
        .noise_floor_db   (noise_floor_db),
        .peak_abs         (peak_abs),
        .peak_db          (peak_db),
        .dynamic_range_db (dynamic_range_db),
        .tail_start       (tail_start),
        .tail_count       (tail_count),
        .tail_clamped     (tail_clamped)
    );

endmodule
